### src/pwl_pkg.sv
package pwl_pkg;

  localparam int POINTS     = 8;
  localparam int NPTS       = (POINTS < 2) ? 2 : ((POINTS > 8) ? 8 : POINTS);
  localparam int NREGS      = 8;
  localparam int IDX_W      = 3;
  localparam int ADC_W      = 16;
  localparam int TEMP_W     = 8;
  localparam int PT_W       = 24;
  localparam int PROD_W     = ADC_W + TEMP_W;
  localparam int DIV_BITS   = 4;
  localparam int DIV_STAGES = PROD_W / DIV_BITS;
  localparam int LAT        = DIV_STAGES + 3;
  localparam int VAL_W      = PROD_W + 2;

  typedef logic [NREGS-1:0][PT_W-1:0] pt_arr_t;

  typedef struct packed {
    logic [TEMP_W-1:0] tref;
    logic [TEMP_W-1:0] dt_mag;
    logic              dt_neg;
    logic [ADC_W-1:0]  dx;
    logic [ADC_W-1:0]  den_mag;
    logic              den_neg;
    logic              den_zero;
  } seg_t;

  typedef struct packed {
    logic [TEMP_W-1:0] tref;
    logic              q_neg;
    logic              den_zero;
    logic [ADC_W-1:0]  den_mag;
    logic [ADC_W-1:0]  rem;
    logic [PROD_W-1:0] num;
  } div_t;

  function automatic logic [ADC_W-1:0] adc_of(input logic [PT_W-1:0] p);
    return p[ADC_W-1:0];
  endfunction

  function automatic logic [TEMP_W-1:0] temp_of(input logic [PT_W-1:0] p);
    return p[ADC_W+TEMP_W-1:ADC_W];
  endfunction

endpackage

### src/pwl_seg.sv
module pwl_seg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [pwl_pkg::ADC_W-1:0]     adc,
  input  pwl_pkg::pt_arr_t              points,
  output logic                          valid_r,
  output pwl_pkg::seg_t                 seg_r
);

  function automatic pwl_pkg::seg_t make_seg(
    input logic [pwl_pkg::TEMP_W-1:0] tref,
    input logic [pwl_pkg::TEMP_W-1:0] t_from,
    input logic [pwl_pkg::TEMP_W-1:0] t_to,
    input logic [pwl_pkg::ADC_W-1:0]  a_from,
    input logic [pwl_pkg::ADC_W-1:0]  a_to,
    input logic [pwl_pkg::ADC_W-1:0]  dx
  );
    logic [pwl_pkg::TEMP_W:0] dt;
    logic [pwl_pkg::ADC_W:0]  den;
    pwl_pkg::seg_t            s;
    dt         = {1'b0, t_to} - {1'b0, t_from};
    den        = {1'b0, a_to} - {1'b0, a_from};
    s.tref     = tref;
    s.dt_neg   = dt[pwl_pkg::TEMP_W];
    s.dt_mag   = dt[pwl_pkg::TEMP_W] ? pwl_pkg::TEMP_W'(-dt) : dt[pwl_pkg::TEMP_W-1:0];
    s.dx       = dx;
    s.den_neg  = den[pwl_pkg::ADC_W];
    s.den_mag  = den[pwl_pkg::ADC_W] ? pwl_pkg::ADC_W'(-den) : den[pwl_pkg::ADC_W-1:0];
    s.den_zero = (den == '0);
    return s;
  endfunction

  pwl_pkg::seg_t lane [pwl_pkg::NPTS+1];
  pwl_pkg::seg_t sel;

  // lane k: sample below point k; last lane: at or above the last point
  for (genvar k = 0; k < pwl_pkg::NPTS; k++) begin : g_lane
    if (k == 0) begin : g_first
      assign lane[k] = make_seg('0, '0, pwl_pkg::temp_of(points[0]), '0,
                                pwl_pkg::adc_of(points[0]), adc);
    end else begin : g_mid
      assign lane[k] = make_seg(pwl_pkg::temp_of(points[k-1]),
                                pwl_pkg::temp_of(points[k-1]),
                                pwl_pkg::temp_of(points[k]),
                                pwl_pkg::adc_of(points[k-1]),
                                pwl_pkg::adc_of(points[k]),
                                adc - pwl_pkg::adc_of(points[k-1]));
    end
  end

  assign lane[pwl_pkg::NPTS] = make_seg(pwl_pkg::temp_of(points[pwl_pkg::NPTS-1]),
                                        pwl_pkg::temp_of(points[pwl_pkg::NPTS-2]),
                                        pwl_pkg::temp_of(points[pwl_pkg::NPTS-1]),
                                        pwl_pkg::adc_of(points[pwl_pkg::NPTS-2]),
                                        pwl_pkg::adc_of(points[pwl_pkg::NPTS-1]),
                                        adc - pwl_pkg::adc_of(points[pwl_pkg::NPTS-1]));

  // first point above the sample wins
  always_comb begin
    sel = lane[pwl_pkg::NPTS];
    for (int k = pwl_pkg::NPTS - 1; k >= 0; k--) begin
      if (adc < pwl_pkg::adc_of(points[k])) begin
        sel = lane[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    seg_r <= sel;
  end

endmodule

### src/pwl_mul.sv
module pwl_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pwl_pkg::seg_t seg,
  output logic          valid_r,
  output pwl_pkg::div_t div_r
);

  pwl_pkg::div_t div_nxt;

  always_comb begin
    div_nxt.tref     = seg.tref;
    div_nxt.q_neg    = seg.dt_neg ^ seg.den_neg;
    div_nxt.den_zero = seg.den_zero;
    div_nxt.den_mag  = seg.den_mag;
    div_nxt.rem      = '0;
    div_nxt.num      = pwl_pkg::PROD_W'(seg.dt_mag) * pwl_pkg::PROD_W'(seg.dx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
  end

endmodule

### src/pwl_div_stage.sv
module pwl_div_stage (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  pwl_pkg::div_t din,
  output logic          valid_r,
  output pwl_pkg::div_t d_r
);

  pwl_pkg::div_t d_nxt;

  // restoring division, quotient bits shift into num from the bottom
  always_comb begin
    logic [pwl_pkg::ADC_W:0] t;
    logic                    ge;
    d_nxt = din;
    for (int k = 0; k < pwl_pkg::DIV_BITS; k++) begin
      t         = {d_nxt.rem, d_nxt.num[pwl_pkg::PROD_W-1]};
      ge        = (t >= {1'b0, d_nxt.den_mag});
      d_nxt.num = {d_nxt.num[pwl_pkg::PROD_W-2:0], ge};
      d_nxt.rem = ge ? pwl_pkg::ADC_W'(t - {1'b0, d_nxt.den_mag})
                     : t[pwl_pkg::ADC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    d_r <= d_nxt;
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !d_r.den_zero |-> d_r.rem < d_r.den_mag)
    else $error("partial remainder not below divisor");

endmodule

### src/pwl_sat.sv
module pwl_sat (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  pwl_pkg::div_t                  din,
  output logic                           valid_r,
  output logic [pwl_pkg::TEMP_W-1:0]     temp_r,
  output logic                           clip_r,
  output logic                           fault_r
);

  logic signed [pwl_pkg::VAL_W-1:0] quo;
  logic signed [pwl_pkg::VAL_W-1:0] val;
  logic [pwl_pkg::TEMP_W-1:0]       temp_nxt;
  logic                             clip_nxt;
  logic                             fault_nxt;

  always_comb begin
    quo = din.q_neg ? -$signed({2'b00, din.num}) : $signed({2'b00, din.num});
    val = quo + $signed(pwl_pkg::VAL_W'(din.tref));
    temp_nxt  = '0;
    clip_nxt  = 1'b0;
    fault_nxt = 1'b0;
    if (din.den_zero) begin
      fault_nxt = 1'b1;
    end else if (val < 0) begin
      clip_nxt = 1'b1;
    end else if (val > $signed(pwl_pkg::VAL_W'({pwl_pkg::TEMP_W{1'b1}}))) begin
      temp_nxt = '1;
      clip_nxt = 1'b1;
    end else begin
      temp_nxt = val[pwl_pkg::TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    temp_r  <= temp_nxt;
    clip_r  <= clip_nxt;
    fault_r <= fault_nxt;
  end

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && fault_r |-> temp_r == '0 && !clip_r)
    else $error("fault result not zeroed");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && clip_r |-> temp_r == '0 || temp_r == '1)
    else $error("clipped result off the rails");

endmodule

### src/piecewise_linear_adc_to_temperature_unit.sv
// ADC sample to temperature through an 8-point calibration table.
//
// Config: cfg_valid/cfg_ready write channel, cfg_ready is always high.
//   cfg_index selects point_0..point_7, cfg_data[15:0] is the ADC value,
//   cfg_data[23:16] the temperature. Write the table while no request is in
//   flight.
// Requests: a sample on in_adc_sample is taken when start is high and busy is
//   low. busy stays low, so one request can be issued every cycle.
// Results: out_valid is high for one cycle with out_temperature, out_clipped
//   and out_fault. Each request's result is registered through every stage
//   listed below, in that order (throughput 1/cycle).
//   Stages: segment select, multiply, six 4-bit divider stages, saturate.
//   The pipeline depth is set by the 24-bit pipelined divider.
// Reset: rst_n (sync, active low) empties the pipeline and zeroes every
//   point; with that table every result reports fault.
// The receiver cannot stall: results are dropped if not taken.
module piecewise_linear_adc_to_temperature_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [pwl_pkg::ADC_W-1:0]     in_adc_sample,
  output logic                          out_valid,
  output logic [pwl_pkg::TEMP_W-1:0]    out_temperature,
  output logic                          out_clipped,
  output logic                          out_fault,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pwl_pkg::IDX_W-1:0]     cfg_index,
  input  logic [pwl_pkg::PT_W-1:0]      cfg_data
);

  pwl_pkg::pt_arr_t points_r;
  logic             in_valid;
  logic             seg_valid;
  pwl_pkg::seg_t    seg;
  logic             dv_valid [pwl_pkg::DIV_STAGES+1];
  pwl_pkg::div_t    dv       [pwl_pkg::DIV_STAGES+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_valid  = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      points_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      points_r[cfg_index] <= cfg_data;
    end
  end

  pwl_seg u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .adc      (in_adc_sample),
    .points   (points_r),
    .valid_r  (seg_valid),
    .seg_r    (seg)
  );

  pwl_mul u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (seg_valid),
    .seg      (seg),
    .valid_r  (dv_valid[0]),
    .div_r    (dv[0])
  );

  for (genvar s = 0; s < pwl_pkg::DIV_STAGES; s++) begin : g_div
    pwl_div_stage u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (dv_valid[s]),
      .din      (dv[s]),
      .valid_r  (dv_valid[s+1]),
      .d_r      (dv[s+1])
    );
  end

  pwl_sat u_sat (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (dv_valid[pwl_pkg::DIV_STAGES]),
    .din      (dv[pwl_pkg::DIV_STAGES]),
    .valid_r  (out_valid),
    .temp_r   (out_temperature),
    .clip_r   (out_clipped),
    .fault_r  (out_fault)
  );

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, pwl_pkg::LAT))
    else $error("result without a matching request");

endmodule

### verif/tb_top.sv
module tb_top;

  import pwl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [ADC_W-1:0]  sample;
    logic [TEMP_W-1:0] temperature;
    logic              clipped;
    logic              fault;
  } temp_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [ADC_W-1:0]  in_adc_sample = '0;
  logic              out_valid;
  logic [TEMP_W-1:0] out_temperature;
  logic              out_clipped;
  logic              out_fault;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [PT_W-1:0]   cfg_data = '0;

  pt_arr_t   cal_pts = '0;
  temp_res_t expected_temps[$];
  int        errors = 0;
  int        cycles = 0;
  bit        no_gaps = 1'b0;

  piecewise_linear_adc_to_temperature_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_adc_sample   (in_adc_sample),
    .out_valid       (out_valid),
    .out_temperature (out_temperature),
    .out_clipped     (out_clipped),
    .out_fault       (out_fault),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic longint adc_at(input int k);
    return longint'({48'd0, cal_pts[k][ADC_W-1:0]});
  endfunction

  function automatic longint temp_at(input int k);
    return longint'({56'd0, cal_pts[k][ADC_W+TEMP_W-1:ADC_W]});
  endfunction

  function automatic logic [PT_W-1:0] mk_point(input int adc, input int temp);
    return {temp[TEMP_W-1:0], adc[ADC_W-1:0]};
  endfunction

  function automatic temp_res_t predict_temp(input logic [ADC_W-1:0] x);
    temp_res_t r;
    int        seg;
    longint    xs, tref, dt, dx, den, val;
    xs = longint'({48'd0, x});
    seg = NPTS;
    for (int k = NPTS - 1; k >= 0; k--)
      if (xs < adc_at(k)) seg = k;
    if (seg == 0) begin
      tref = 0;
      dt   = temp_at(0);
      dx   = xs;
      den  = adc_at(0);
    end else if (seg < NPTS) begin
      tref = temp_at(seg - 1);
      dt   = temp_at(seg) - tref;
      dx   = xs - adc_at(seg - 1);
      den  = adc_at(seg) - adc_at(seg - 1);
    end else begin
      tref = temp_at(NPTS - 1);
      dt   = tref - temp_at(NPTS - 2);
      dx   = xs - adc_at(NPTS - 1);
      den  = adc_at(NPTS - 1) - adc_at(NPTS - 2);
    end
    r.sample      = x;
    r.temperature = '0;
    r.clipped     = 1'b0;
    r.fault       = 1'b0;
    if (den == 0) begin
      r.fault = 1'b1;
    end else begin
      val = tref + (dt * dx) / den;
      if (val < 0) begin
        r.clipped = 1'b1;
      end else if (val > 255) begin
        r.temperature = 8'hFF;
        r.clipped     = 1'b1;
      end else begin
        r.temperature = val[TEMP_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (no_gaps || r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [ADC_W-1:0] pick_sample();
    int               r;
    int               k;
    logic [ADC_W-1:0] v;
    r = $urandom_range(0, 9);
    k = $urandom_range(0, NPTS - 1);
    if (r < 5) begin
      v = ADC_W'($urandom_range(0, 65535));
    end else if (r < 8) begin
      v = cal_pts[k][ADC_W-1:0] + ADC_W'($urandom_range(0, 2)) - 16'd1;
    end else if (r == 8) begin
      v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
    end else begin
      v = ADC_W'($urandom_range(0, 255));
    end
    return v;
  endfunction

  task automatic send_sample(input logic [ADC_W-1:0] x);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start         <= 1'b1;
    in_adc_sample <= x;
    do @(posedge clk); while (busy);
    expected_temps.push_back(predict_temp(x));
  endtask

  // drop start and let the pipeline empty before touching the table
  task automatic wait_idle();
    start <= 1'b0;
    while (expected_temps.size() != 0) @(posedge clk);
    repeat (LAT + 2) @(posedge clk);
  endtask

  task automatic load_table(input pt_arr_t tbl);
    wait_idle();
    for (int k = 0; k < NREGS; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= k[IDX_W-1:0];
      cfg_data  <= tbl[k];
      do @(posedge clk); while (!cfg_ready);
      cal_pts[k] = tbl[k];
    end
    cfg_valid <= 1'b0;
  endtask

  always @(negedge clk) begin : check_results
    temp_res_t e;
    if (rst_n && out_valid) begin
      if (expected_temps.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: temp %0d clip %b fault %b",
                   out_temperature, out_clipped, out_fault);
        errors++;
      end else begin
        e = expected_temps.pop_front();
        if (out_temperature !== e.temperature || out_clipped !== e.clipped ||
            out_fault !== e.fault) begin
          if (errors < 10)
            $display("sample %h: expected temp %0d clip %b fault %b, got %0d %b %b",
                     e.sample, e.temperature, e.clipped, e.fault,
                     out_temperature, out_clipped, out_fault);
          errors++;
        end
      end
    end
  end

  // all-zero table after reset: every request reports fault
  task automatic test_reset_table();
    send_sample(16'h0000);
    send_sample(16'hFFFF);
    send_sample(16'h5555);
    send_sample(16'hAAAA);
  endtask

  task automatic test_interpolation();
    int      adc_v[8]  = '{1000, 5000, 10000, 20000, 30000, 40000, 50000, 60000};
    int      temp_v[8] = '{10, 30, 60, 100, 140, 180, 220, 250};
    int      smp[8]    = '{0, 999, 1000, 1001, 15000, 59999, 60000, 65535};
    pt_arr_t tbl;
    for (int k = 0; k < NREGS; k++) tbl[k] = mk_point(adc_v[k], temp_v[k]);
    load_table(tbl);
    for (int k = 0; k < 8; k++) send_sample(smp[k][ADC_W-1:0]);
  endtask

  task automatic test_edge_tables();
    int      adc_u[8]  = '{40000, 30000, 20000, 10000, 50000, 45000, 200, 100};
    int      temp_u[8] = '{90, 70, 50, 30, 120, 110, 10, 200};
    pt_arr_t tbl;
    for (int k = 0; k < NREGS; k++) tbl[k] = 24'hFFFFFF;
    load_table(tbl);
    send_sample(16'hFFFE);
    send_sample(16'hFFFF);
    // falling temperatures: extrapolation runs below zero
    for (int k = 0; k < NREGS; k++) tbl[k] = mk_point(100 * (k + 1), 255 - 35 * k);
    load_table(tbl);
    send_sample(16'd150);
    send_sample(16'hFFFF);
    // unsorted: negative divisor in the top range
    for (int k = 0; k < NREGS; k++) tbl[k] = mk_point(adc_u[k], temp_u[k]);
    load_table(tbl);
    send_sample(16'hFFFF);
    send_sample(16'd35000);
    send_sample(16'd45000);
    // last two points equal: zero divisor above them
    for (int k = 0; k < NREGS; k++) tbl[k] = mk_point(k < 7 ? 10 * k : 60, 20 * k);
    load_table(tbl);
    send_sample(16'd70);
    send_sample(16'd5);
    send_sample(16'd0);
  endtask

  task automatic test_random_tables();
    int      adc_v[8];
    int      temp_v[8];
    int      kind, base, tmp;
    pt_arr_t tbl;
    repeat (20) begin
      kind = $urandom_range(0, 5);
      base = $urandom_range(0, 65000);
      for (int k = 0; k < 8; k++) begin
        adc_v[k]  = (kind == 1) ? base + $urandom_range(0, 500) : $urandom_range(0, 65535);
        temp_v[k] = $urandom_range(0, 255);
        if (kind == 4) begin
          case ($urandom_range(0, 3))
            0: adc_v[k] = 0;
            1: adc_v[k] = 1;
            2: adc_v[k] = 65534;
            default: adc_v[k] = 65535;
          endcase
          temp_v[k] = $urandom_range(0, 1) ? 255 : 0;
        end
      end
      if (kind != 2) begin
        for (int i = 0; i < 7; i++)
          for (int j = 0; j < 7 - i; j++) begin
            if (adc_v[j] > adc_v[j+1]) begin
              tmp = adc_v[j]; adc_v[j] = adc_v[j+1]; adc_v[j+1] = tmp;
            end
            if (temp_v[j] > temp_v[j+1]) begin
              tmp = temp_v[j]; temp_v[j] = temp_v[j+1]; temp_v[j+1] = tmp;
            end
          end
      end
      if (kind == 3)
        for (int k = 1; k < 8; k++)
          if ($urandom_range(0, 2) == 0) adc_v[k] = adc_v[k-1];
      for (int k = 0; k < NREGS; k++)
        tbl[k] = mk_point(adc_v[k], (kind == 5) ? temp_v[7-k] : temp_v[k]);
      load_table(tbl);
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat (95) send_sample(pick_sample());
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_table();
    test_interpolation();
    test_edge_tables();
    test_random_tables();
    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### filelist.f
src/pwl_pkg.sv
src/pwl_seg.sv
src/pwl_mul.sv
src/pwl_div_stage.sv
src/pwl_sat.sv
src/piecewise_linear_adc_to_temperature_unit.sv
verif/tb_top.sv
